>>> rtl/core/clook_pkg.sv
// Shared types and constants for the C-LOOK disk scheduler.
// Used by every module under rtl/core; depends on nothing else.
package clook_pkg;

	// Store geometry and field widths
	localparam int QUEUE_DEPTH   = 32;
	localparam int CYLINDER_BITS = 16;
	localparam int CYL_BITS      = CYLINDER_BITS;
	localparam int ADDR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
	localparam int PORT_CYL_W    = 16;
	localparam int MOVE_W        = 22;
	localparam int SUM_W         = ((CYL_BITS > MOVE_W) ? CYL_BITS : MOVE_W) + 1;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 16;

	localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [MOVE_W-1:0] MOVE_MAX  = {MOVE_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TOWARD_HIGH = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_PLACE,
		ST_SCAN,
		ST_SETUP,
		ST_SRD,
		ST_SDATA
	} state_t;

	// Request store access for one cycle
	typedef struct packed {
		logic                we;
		logic [ADDR_W-1:0]   waddr;
		logic [CYL_BITS-1:0] wdata;
		logic                re;
		logic [ADDR_W-1:0]   raddr;
	} ram_req_t;

	// One served request headed for the output register
	typedef struct packed {
		logic                  valid;
		logic [PORT_CYL_W-1:0] cyl;
		logic [MOVE_W-1:0]     total;
		logic                  last;
	} result_t;

endpackage

>>> rtl/core/clook_ram.sv
// Request store: one write port, one read port, registered read data.
// Depends on clook_pkg for depth and widths.
module clook_ram
	import clook_pkg::*;
(
	input  logic                clk,
	input  ram_req_t            req,
	output logic [CYL_BITS-1:0] rd_data
);

	logic [CYL_BITS-1:0] mem [QUEUE_DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Read one entry, data valid next cycle
	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_data <= mem[req.raddr];
		end
	end

endmodule

>>> rtl/core/clook_move.sv
// Head movement accumulator: absolute seek distance added to the running total.
// Depends on clook_pkg for widths and the saturation limit.
module clook_move
	import clook_pkg::*;
(
	input  logic [CYL_BITS-1:0] head,
	input  logic [CYL_BITS-1:0] cyl,
	input  logic [MOVE_W-1:0]   total,
	input  logic                counted,
	output logic [MOVE_W-1:0]   next_total
);

	logic [CYL_BITS-1:0] seek_len;
	logic [SUM_W-1:0]    sum;

	// Seek distance between head and target cylinder
	assign seek_len = (cyl > head) ? (cyl - head) : (head - cyl);
	assign sum      = SUM_W'(total) + SUM_W'(seek_len);

	// Saturate the total; the wrap jump adds nothing
	always_comb begin
		if (!counted) begin
			next_total = total;
		end else if (sum > SUM_W'(MOVE_MAX)) begin
			next_total = MOVE_MAX;
		end else begin
			next_total = MOVE_W'(sum);
		end
	end

endmodule

>>> rtl/core/clook_ctrl.sv
// Scheduler sequencer: sorted insert into the store, split scan, C-LOOK service.
// Depends on clook_pkg and clook_move; drives the request store port.
module clook_ctrl
	import clook_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PORT_CYL_W-1:0] request_cylinder,
	input  logic                  last_request,
	input  logic [CFG_DATA_W-1:0] start_head,
	input  logic                  toward_high,
	input  logic                  out_free,
	output ram_req_t              ram_req,
	input  logic [CYL_BITS-1:0]   rd_data,
	output result_t               res
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    pos_q;
	logic [CNT_W-1:0]    scan_q;
	logic [CNT_W-1:0]    split_q;
	logic [CNT_W-1:0]    k_q;
	logic [CNT_W-1:0]    wrap_k_q;
	logic [ADDR_W-1:0]   idx_q;
	logic                pend_q;
	logic                dir_q;
	logic                last_q;
	logic [CYL_BITS-1:0] v_q;
	logic [CYL_BITS-1:0] head_q;
	logic [MOVE_W-1:0]   total_q;

	logic [CYL_BITS-1:0] in_cyl;
	logic [CYL_BITS-1:0] head_cfg;
	logic [CNT_W-1:0]    cnt_m1;
	logic [CNT_W-1:0]    pos_m1;
	logic [CNT_W-1:0]    pos_m2;
	logic [CNT_W-1:0]    idx_init;
	logic                accept;
	logic                has_room;
	logic                shift;
	logic                counted;
	logic                is_last;
	logic [MOVE_W-1:0]   next_total;

	assign in_cyl   = CYL_BITS'(request_cylinder);
	assign head_cfg = CYL_BITS'(start_head);
	assign cnt_m1   = count_q - CNT_W'(1);
	assign pos_m1   = pos_q - CNT_W'(1);
	assign pos_m2   = pos_q - CNT_W'(2);
	assign accept   = in_valid && (state_q == ST_IDLE);
	assign has_room = count_q < DEPTH_CNT;
	assign shift    = rd_data > v_q;
	assign counted  = k_q != wrap_k_q;
	assign is_last  = k_q == cnt_m1;

	// First index served: upward starts at the split, downward just below it
	always_comb begin
		if (toward_high) begin
			idx_init = (split_q == count_q) ? '0 : split_q;
		end else begin
			idx_init = (split_q == '0) ? cnt_m1 : (split_q - CNT_W'(1));
		end
	end

	clook_move u_move (
		.head       (head_q),
		.cyl        (rd_data),
		.total      (total_q),
		.counted    (counted),
		.next_total (next_total)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (has_room && (count_q != '0)) begin
						state_d = ST_INS;
					end else if (last_request) begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_INS: begin
				if (shift && (pos_q == CNT_W'(1))) begin
					state_d = ST_PLACE;
				end else if (!shift) begin
					state_d = last_q ? ST_SCAN : ST_IDLE;
				end
			end
			ST_PLACE: state_d = last_q ? ST_SCAN : ST_IDLE;
			ST_SCAN: begin
				if ((scan_q == count_q) && !pend_q) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: state_d = ST_SRD;
			ST_SRD: begin
				if (out_free) begin
					state_d = ST_SDATA;
				end
			end
			ST_SDATA: state_d = is_last ? ST_IDLE : ST_SRD;
			default: state_d = ST_IDLE;
		endcase
	end

	// Store accesses, input stall and result strobe
	always_comb begin
		ram_req   = '0;
		in_stall  = state_q != ST_IDLE;
		res.valid = 1'b0;
		res.cyl   = PORT_CYL_W'(rd_data);
		res.total = next_total;
		res.last  = is_last;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && has_room) begin
					if (count_q == '0) begin
						ram_req.we    = 1'b1;
						ram_req.waddr = '0;
						ram_req.wdata = in_cyl;
					end else begin
						ram_req.re    = 1'b1;
						ram_req.raddr = cnt_m1[ADDR_W-1:0];
					end
				end
			end
			ST_INS: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q[ADDR_W-1:0];
				ram_req.wdata = shift ? rd_data : v_q;
				if (shift && (pos_q != CNT_W'(1))) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = pos_m2[ADDR_W-1:0];
				end
			end
			ST_PLACE: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = pos_q[ADDR_W-1:0];
				ram_req.wdata = v_q;
			end
			ST_SCAN: begin
				if (scan_q != count_q) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = scan_q[ADDR_W-1:0];
				end
			end
			ST_SETUP: begin
			end
			ST_SRD: begin
				if (out_free) begin
					ram_req.re    = 1'b1;
					ram_req.raddr = idx_q;
				end
			end
			ST_SDATA: res.valid = 1'b1;
			default: begin
			end
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Track the fill count and the scan pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (state_q != ST_SCAN) begin
				pend_q <= 1'b0;
			end else begin
				pend_q <= scan_q != count_q;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && has_room && (count_q == '0)) begin
						count_q <= CNT_W'(1);
					end
				end
				ST_INS: begin
					if (!shift) begin
						count_q <= count_q + CNT_W'(1);
					end
				end
				ST_PLACE: count_q <= count_q + CNT_W'(1);
				ST_SDATA: begin
					if (is_last) begin
						count_q <= '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the datapath
	always_ff @(posedge clk) begin
		if (state_q != ST_SCAN) begin
			scan_q  <= '0;
			split_q <= (state_q == ST_SETUP || state_q == ST_SRD || state_q == ST_SDATA)
				? split_q : '0;
		end
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					v_q    <= in_cyl;
					last_q <= last_request;
					pos_q  <= count_q;
				end
			end
			ST_INS: begin
				if (shift) begin
					pos_q <= pos_m1;
				end
			end
			ST_SCAN: begin
				if (scan_q != count_q) begin
					scan_q <= scan_q + CNT_W'(1);
				end
				if (pend_q && (rd_data <= head_cfg)) begin
					split_q <= split_q + CNT_W'(1);
				end
			end
			ST_SETUP: begin
				idx_q    <= idx_init[ADDR_W-1:0];
				dir_q    <= toward_high;
				k_q      <= '0;
				wrap_k_q <= toward_high ? (count_q - split_q) : split_q;
				head_q   <= head_cfg;
				total_q  <= '0;
			end
			ST_SDATA: begin
				head_q  <= rd_data;
				total_q <= next_total;
				k_q     <= k_q + CNT_W'(1);
				if (dir_q) begin
					idx_q <= (idx_q == cnt_m1[ADDR_W-1:0]) ? '0 : (idx_q + ADDR_W'(1));
				end else begin
					idx_q <= (idx_q == '0) ? cnt_m1[ADDR_W-1:0] : (idx_q - ADDR_W'(1));
				end
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/core/clook_disk_scheduler.sv
// C-LOOK disk scheduler top level. A request is written straight into an empty store and
// dropped by a full one; otherwise the sorted insert shifts each stored larger cylinder up.
// After the final request the split scan reads every stored request, then results are
// served one at a time through the store's single read port, held while the output stalls.
// Reset clears control state and configuration (start_head 0, toward_high 1);
// the request store is not cleared and needs no clearing pass.
module clook_disk_scheduler
	import clook_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PORT_CYL_W-1:0] request_cylinder,
	input  logic                  last_request,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [PORT_CYL_W-1:0] served_cylinder,
	output logic [MOVE_W-1:0]     total_movement,
	output logic                  last_served
);

	logic [CFG_DATA_W-1:0] start_head_q;
	logic                  toward_high_q;
	logic                  out_valid_q;
	logic [PORT_CYL_W-1:0] served_q;
	logic [MOVE_W-1:0]     total_q;
	logic                  last_q;
	logic                  out_free;
	ram_req_t              ram_req;
	logic [CYL_BITS-1:0]   rd_data;
	result_t               res;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_head_q  <= '0;
			toward_high_q <= 1'b1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_HEAD:  start_head_q  <= cfg_data;
				REG_TOWARD_HIGH: toward_high_q <= cfg_data[0];
			endcase
		end
	end

	clook_ram u_ram (
		.clk     (clk),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	clook_ctrl u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.request_cylinder (request_cylinder),
		.last_request     (last_request),
		.start_head       (start_head_q),
		.toward_high      (toward_high_q),
		.out_free         (out_free),
		.ram_req          (ram_req),
		.rd_data          (rd_data),
		.res              (res)
	);

	assign out_free = !out_valid_q || !out_stall;

	// Output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			served_q <= res.cyl;
			total_q  <= res.total;
			last_q   <= res.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign served_cylinder = served_q;
	assign total_movement  = total_q;
	assign last_served     = last_q;

endmodule

>>> bench/tb_clook_disk_scheduler.sv
`timescale 1ns / 100ps
// Self-checking bench for clook_disk_scheduler: drives cylinder request batches,
// predicts the C-LOOK service order and running head movement, and checks each result.
// Depends on clook_pkg and the scheduler RTL only.
module tb_clook_disk_scheduler;
	import clook_pkg::*;

	localparam int CYCLE_LIMIT   = 500000;
	localparam int SETTLE_CYCLES = 120;
	localparam int MAX_REPORTS   = 10;

	// One served request as the block should report it
	typedef struct packed {
		logic [PORT_CYL_W-1:0] cyl;
		logic [MOVE_W-1:0]     total;
		logic                  last;
	} served_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic [PORT_CYL_W-1:0] request_cylinder;
	logic                  last_request;
	logic                  out_valid;
	logic                  out_stall;
	logic [PORT_CYL_W-1:0] served_cylinder;
	logic [MOVE_W-1:0]     total_movement;
	logic                  last_served;

	// Shadow configuration and batch state
	logic [PORT_CYL_W-1:0] start_head_cfg;
	logic                  sweep_up_cfg;
	logic [PORT_CYL_W-1:0] batch_store [QUEUE_DEPTH];
	int                    batch_count;
	logic [PORT_CYL_W-1:0] sweep_head;
	logic [MOVE_W-1:0]     sweep_total;

	served_t pending_served [$];
	int      mismatch_count;
	int      cycle_count;
	int      send_gap_pct;
	int      recv_stall_pct;

	clook_disk_scheduler i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.request_cylinder (request_cylinder),
		.last_request     (last_request),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.served_cylinder  (served_cylinder),
		.total_movement   (total_movement),
		.last_served      (last_served)
	);

	always #10 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stall the result side at random
	always @(negedge clk) begin
		out_stall = ($urandom_range(99) < recv_stall_pct);
	end

	// Move the head to one cylinder, adding its distance unless this is the wrap jump
	function automatic void serve_cylinder(input logic [PORT_CYL_W-1:0] cyl,
			input logic counted);
		logic [MOVE_W:0] sum;
		if (counted) begin
			sum = sweep_total + ((cyl > sweep_head) ? cyl - sweep_head : sweep_head - cyl);
			sweep_total = (sum > MOVE_MAX) ? MOVE_MAX : sum[MOVE_W-1:0];
		end
		sweep_head = cyl;
		pending_served.push_back('{cyl: cyl, total: sweep_total, last: 1'b0});
	endfunction

	// Store one accepted request; on the final one, schedule the batch
	function automatic void predict_request(input logic [PORT_CYL_W-1:0] cyl,
			input logic last);
		logic [PORT_CYL_W-1:0] sorted [QUEUE_DEPTH];
		logic [PORT_CYL_W-1:0] v;
		int n, split, i, j;
		if (batch_count < QUEUE_DEPTH) begin
			batch_store[batch_count] = cyl;
			batch_count++;
		end
		if (!last)
			return;
		n = batch_count;
		batch_count = 0;
		for (i = 0; i < n; i++)
			sorted[i] = batch_store[i];
		for (i = 1; i < n; i++) begin
			v = sorted[i];
			j = i;
			while (j > 0 && sorted[j-1] > v) begin
				sorted[j] = sorted[j-1];
				j--;
			end
			sorted[j] = v;
		end
		sweep_head = start_head_cfg;
		sweep_total = '0;
		// A request equal to the head counts as lying below it
		split = n;
		for (i = 0; i < n; i++) begin
			if (sweep_head < sorted[i]) begin
				split = i;
				break;
			end
		end
		if (sweep_up_cfg) begin
			for (i = split; i < n; i++)
				serve_cylinder(sorted[i], 1'b1);
			if (split > 0) begin
				serve_cylinder(sorted[0], 1'b0);
				for (i = 1; i < split; i++)
					serve_cylinder(sorted[i], 1'b1);
			end
		end else begin
			for (i = split; i > 0; i--)
				serve_cylinder(sorted[i-1], 1'b1);
			if (split < n) begin
				serve_cylinder(sorted[n-1], 1'b0);
				for (i = n - 1; i > split; i--)
					serve_cylinder(sorted[i-1], 1'b1);
			end
		end
		if (n > 0)
			pending_served[pending_served.size()-1].last = 1'b1;
	endfunction

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		served_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_served.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("unexpected result: cyl %0d total %0d last %0b",
						served_cylinder, total_movement, last_served);
			end else begin
				want = pending_served.pop_front();
				if (want.cyl !== served_cylinder || want.total !== total_movement ||
						want.last !== last_served) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("mismatch: cyl %0d/%0d total %0d/%0d last %0b/%0b (exp/act)",
							want.cyl, served_cylinder, want.total, total_movement,
							want.last, last_served);
				end
			end
		end
	end

	// Drop valid and hold until every expected result has come, then settle
	task automatic wait_drained(input int settle);
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_served.size() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	// Present one request and hold it until accepted
	task automatic send_request(input logic [PORT_CYL_W-1:0] cyl, input logic last);
		@(negedge clk);
		if ($urandom_range(99) < send_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		request_cylinder = cyl;
		last_request = last;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		predict_request(cyl, last);
	endtask

	// Write both registers once the block is idle
	task automatic set_config(input logic [PORT_CYL_W-1:0] head, input logic up,
			input logic [CFG_DATA_W-2:0] dir_pad);
		wait_drained(SETTLE_CYCLES);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = REG_START_HEAD;
		cfg_data = head;
		start_head_cfg = head;
		@(negedge clk);
		cfg_index = REG_TOWARD_HIGH;
		cfg_data = {dir_pad, up};
		sweep_up_cfg = up;
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// One-request batches at the cylinder extremes
	task automatic test_single_request();
		set_config(16'd0, 1'b1, '0);
		send_request(16'd0, 1'b1);
		send_request(16'hFFFF, 1'b1);
		set_config(16'hFFFF, 1'b0, '1);
		send_request(16'hFFFF, 1'b1);
	endtask

	// Head at either end: nothing above it at the top, only a request equal to it below it at zero
	task automatic test_head_extremes();
		set_config(16'hFFFF, 1'b1, '0);
		send_request(16'hFFFF, 1'b0);
		send_request(16'd0, 1'b0);
		send_request(16'h8000, 1'b0);
		send_request(16'd1, 1'b1);
		set_config(16'd0, 1'b0, '0);
		send_request(16'd0, 1'b0);
		send_request(16'd40000, 1'b0);
		send_request(16'hFFFF, 1'b1);
	endtask

	// Empty first side, duplicates around the head, both directions
	task automatic test_empty_side();
		logic [PORT_CYL_W-1:0] mix [6];
		mix = '{16'd29999, 16'd30000, 16'd30001, 16'hFFFF, 16'd0, 16'd30001};
		set_config(16'd100, 1'b0, '0);
		send_request(16'd500, 1'b0);
		send_request(16'd300, 1'b0);
		send_request(16'hFFFF, 1'b1);
		set_config(16'd30000, 1'b1, '0);
		foreach (mix[i])
			send_request(mix[i], i == 5);
		set_config(16'd30000, 1'b0, '0);
		foreach (mix[i])
			send_request(mix[i], i == 5);
	endtask

	// Overfill the store: extra requests and the final one are dropped
	task automatic test_full_store();
		set_config(PORT_CYL_W'($urandom_range(0, 65535)), 1'b1, '0);
		for (int i = 0; i < QUEUE_DEPTH + 2; i++)
			send_request(PORT_CYL_W'($urandom_range(0, 65535)), i == QUEUE_DEPTH + 1);
	endtask

	// Random batches with random configuration under one idling setting
	task automatic test_random_phase(input int gap_pct, input int stall_pct,
			input int item_goal);
		int sent, size, c, pick;
		logic [PORT_CYL_W-1:0] head;
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		sent = 0;
		while (sent < item_goal) begin
			// Reconfigure now and then, with extreme heads among the picks
			if ($urandom_range(99) < 35) begin
				pick = $urandom_range(9);
				head = (pick == 0) ? 16'd0 : (pick == 1) ? 16'hFFFF :
					PORT_CYL_W'($urandom_range(0, 65535));
				set_config(head, 1'($urandom_range(1)),
					(CFG_DATA_W-1)'($urandom_range(0, 32767)));
			end
			pick = $urandom_range(99);
			size = (pick < 70) ? $urandom_range(1, 8) :
				(pick < 95) ? $urandom_range(9, QUEUE_DEPTH) :
				$urandom_range(QUEUE_DEPTH + 1, QUEUE_DEPTH + 4);
			for (int i = 0; i < size; i++) begin
				// Hold off now and then until every result is in
				if ($urandom_range(99) < 3)
					wait_drained(0);
				pick = $urandom_range(99);
				if (pick < 50)
					c = $urandom_range(0, 65535);
				else if (pick < 80)
					c = int'(start_head_cfg) + int'($urandom_range(0, 200)) - 100;
				else
					c = (pick < 87) ? 0 : (pick < 94) ? 65535 : int'(start_head_cfg);
				if (c < 0)
					c = 0;
				if (c > 65535)
					c = 65535;
				send_request(PORT_CYL_W'(c), i == size - 1);
			end
			sent += size;
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_START_HEAD;
		cfg_data = '0;
		in_valid = 1'b0;
		request_cylinder = '0;
		last_request = 1'b0;
		out_stall = 1'b0;
		start_head_cfg = '0;
		sweep_up_cfg = 1'b1;
		batch_count = 0;
		sweep_head = '0;
		sweep_total = '0;
		mismatch_count = 0;
		cycle_count = 0;
		send_gap_pct = 26;
		recv_stall_pct = 51;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_single_request();
		test_head_extremes();
		test_empty_side();
		test_full_store();
		test_random_phase(26, 51, 30);
		test_random_phase(51, 26, 30);
		test_random_phase(0, 0, 30);

		wait_drained(SETTLE_CYCLES);
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
